[rtl/ssrq_pkg.sv]
// ----------------------------------------------------------------------------
// ssrq_pkg - shared definitions for the sorted sequence reorder queue
// Entry and control types, opcode and status codes, and sizing constants.
// ----------------------------------------------------------------------------
package ssrq_pkg;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned HANDLE_WIDTH = 8;
  localparam int unsigned KEY_W        = 16;
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned OP_W         = 2;
  localparam int unsigned STATUS_W     = 2;

  localparam int unsigned IN_DATA_W  = ((KEY_W + HANDLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = KEY_W + HANDLE_WIDTH + CNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OP_USER_W  = ((OP_W + 7) / 8) * 8;
  localparam int unsigned ST_USER_W  = ((STATUS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [HANDLE_WIDTH-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t entry;
  } cell_ctrl_t;

endpackage

[rtl/sorted_sequence_reorder_queue.sv]
// ----------------------------------------------------------------------------
// sorted_sequence_reorder_queue - sorted reorder queue of packet handles
// Keeps (sequence number, handle) entries in ascending key order in a chain
// of cells; supports insert, pop front and peek front.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on the s_axis channel carry an opcode in tuser (insert, pop,
//   peek) and the key and handle in tdata. Every beat yields exactly one
//   result beat on m_axis: status in tuser, key, handle and fill count in
//   tdata.
//   The result of a beat accepted at a clock edge is held in the output register
//   and valid in the cycle after. Throughput is one beat per cycle while the
//   receiver takes each result; every cell of the chain compares against the
//   new key and shifts in the same cycle, so the chain settles in a single step.
//   When the receiver stalls, the held result stays put and s_axis_tready
//   drops until it is taken; a new beat enters in the cycle it leaves.
//   Reset empties the queue (fill count zero) and clears the output valid;
//   slot contents are not cleared, as slots at or above the count are never
//   read. Inserts into a full queue are dropped with status full.
// ----------------------------------------------------------------------------
module sorted_sequence_reorder_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [ssrq_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // seq_num, handle
  input  logic [ssrq_pkg::OP_USER_W-1:0]  s_axis_tuser,  // opcode
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [ssrq_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_seq, out_handle, count
  output logic [ssrq_pkg::ST_USER_W-1:0]  m_axis_tuser   // status
);
  import ssrq_pkg::*;

  logic                    accept;
  op_e                     op;
  cell_ctrl_t              ctrl;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q;
  status_e                 status_d, status_q;
  logic [KEY_W-1:0]        oseq_d, oseq_q;
  logic [HANDLE_WIDTH-1:0] ohnd_d, ohnd_q;

  entry_t                  cell_entry [DEPTH];
  logic   [DEPTH-1:0]      cell_lt;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser[OP_W-1:0]);

  always_comb begin
    ctrl.ins          = 1'b0;
    ctrl.pop          = 1'b0;
    ctrl.entry.key    = s_axis_tdata[KEY_W-1:0];
    ctrl.entry.handle = s_axis_tdata[KEY_W +: HANDLE_WIDTH];
    count_d           = count_q;
    status_d          = ST_DONE;
    oseq_d            = '0;
    ohnd_d            = '0;
    unique case (op)
      OP_INSERT: begin
        if (count_q == CNT_W'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = accept;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.pop = accept;
          oseq_d   = cell_entry[0].key;
          ohnd_d   = cell_entry[0].handle;
          count_d  = count_q - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          oseq_d = cell_entry[0].key;
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   slot_valid;
    logic   prev_lt;
    entry_t left_entry;
    entry_t right_entry;

    assign slot_valid = CNT_W'(i) < count_q;

    if (i == 0) begin : g_head
      assign prev_lt    = 1'b1;
      assign left_entry = cell_entry[i];
    end else begin : g_body
      assign prev_lt    = cell_lt[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    ssrq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .valid_i   (slot_valid),
      .front_i   (i == 0),
      .prev_lt_i (prev_lt),
      .left_i    (left_entry),
      .right_i   (right_entry),
      .lt_o      (cell_lt[i]),
      .entry_o   (cell_entry[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result beat until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      oseq_q   <= oseq_d;
      ohnd_q   <= ohnd_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = ST_USER_W'(status_q);
  assign m_axis_tdata  = OUT_DATA_W'({count_q, ohnd_q, oseq_q});

endmodule

[rtl/ssrq_cell.sv]
// ----------------------------------------------------------------------------
// ssrq_cell - one slot of the sorted cell chain
// Holds one entry; keeps it, takes the new entry, or takes a neighbor's.
// ----------------------------------------------------------------------------
module ssrq_cell (
  input  logic                 clk_i,
  input  ssrq_pkg::cell_ctrl_t ctrl_i,
  input  logic                 valid_i,   // slot lies below the fill count
  input  logic                 front_i,   // slot is the head of the chain
  input  logic                 prev_lt_i, // left neighbor keeps its entry on insert
  input  ssrq_pkg::entry_t     left_i,
  input  ssrq_pkg::entry_t     right_i,
  output logic                 lt_o,      // this entry stays ahead of the new one
  output ssrq_pkg::entry_t     entry_o
);
  import ssrq_pkg::*;

  entry_t entry_q, entry_d;

  // a key equal to the head key goes behind the head
  assign lt_o = valid_i && ((entry_q.key < ctrl_i.entry.key) ||
                            (front_i && (entry_q.key == ctrl_i.entry.key)));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (lt_o) begin
        entry_d = entry_q;
      end else if (prev_lt_i) begin
        entry_d = ctrl_i.entry;
      end else begin
        entry_d = left_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
